@@ rtl/core/tkspl_pkg.sv @@
// Shared types and constants for the top-k smallest pair list.
package tkspl_pkg;

  localparam int unsigned IdW       = 32;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned CfgW      = 6;
  localparam int unsigned KindW     = 2;
  localparam int unsigned HeldW     = 6;
  localparam int unsigned InDataW   = 96;
  localparam int unsigned OutDataW  = 200;

  localparam logic [ScoreW-1:0]   ThreshReset   = 32'h7FFF_FFFF;
  localparam logic [2*ScoreW-1:0] ThreshSqReset = 64'h3FFF_FFFF_0000_0001;
  localparam logic [CfgW-1:0]     TopKReset     = 6'd10;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DRAIN  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [IdW-1:0]    left_id;
    logic [IdW-1:0]    right_id;
  } entry_t;

  // Per-cell control, built by the top level for each position of the row.
  typedef struct packed {
    logic ins;    // insert strobe
    logic rot;    // rotate one place towards the head
    logic occ;    // position holds a live entry for the insert
    logic inlim;  // position may change on this insert
    logic tail;   // last live position, takes the head on rotation
  } cell_ctl_t;

endpackage

@@ rtl/core/top_k_smallest_pair_list_top.sv @@
// Top level of the top-k smallest pair list: cell row, control and output register.
//
// Input stream (s_axis): one word per item; tuser gives the kind (insert, drain,
// clear), tdata the pair. Output stream (m_axis): tuser flags a drained entry,
// tdata carries the entry, threshold, its square and the held count, tlast
// marks the final word of an item. Config channel: write top_k while idle.
// The list lives in a row of MAX_K cells. An insert compares the new score
// in every cell at once and shifts the tail by one place in the accept cycle.
// The threshold is then read from the cell at top_k-1 once the list is full, and
// squared by one 32x32 multiplier: an insert steps through the prune, square and
// status states, a clear through square and status; the unused kind and a drain
// of an empty list go straight to status. A drain rotates the row one place per
// output word, waiting on a stalled output, and leaves the list as it was.
// One item is in flight at a time; s_axis_tready is high only when idle.
// A single output register holds the word while m_axis_tready is low; the
// row and the sequencer wait on it. Reset empties the list, sets the
// threshold to 2147483647 and top_k to 10; the cell contents are not cleared.
module top_k_smallest_pair_list_top
  import tkspl_pkg::*;
#(
  parameter int unsigned MAX_K = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: left_id [31:0], right_id [63:32], score [95:64]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: kind [1:0]
  input  logic [KindW-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_left_id [31:0], out_right_id [63:32], out_score [95:64],
  //        threshold [127:96], threshold_sq [191:128], held [197:192], zeros above
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: entry_valid [0]
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  localparam int unsigned KW   = $clog2(MAX_K + 1);
  localparam int unsigned IDXW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PRUNE = 5'b00010,
    ST_SQ    = 5'b00100,
    ST_STAT  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]     top_k_q;
  logic [KW-1:0]       fill_q, fill_d;
  logic [KW-1:0]       cnt_q, cnt_d;
  logic                full_q, full_d;
  logic [ScoreW-1:0]   prune_q, prune_d;
  logic [2*ScoreW-1:0] sq_q, sq_d;

  logic                out_valid_q, out_valid_d;
  logic                out_ev_q, out_ev_d;
  logic                out_last_q, out_last_d;
  entry_t              out_entry_q, out_entry_d;
  logic [ScoreW-1:0]   out_thr_q, out_thr_d;
  logic [2*ScoreW-1:0] out_sq_q, out_sq_d;
  logic [HeldW-1:0]    out_held_q, out_held_d;

  logic [KW-1:0]   k_eff;
  logic [KW-1:0]   n_ins;
  logic [KW-1:0]   lim;
  logic [IDXW-1:0] kidx;
  logic            in_acc;
  logic            out_free;
  logic            do_ins;
  logic            do_rot;
  entry_t          new_entry;
  kind_e           kind;

  entry_t    cell_q  [MAX_K];
  logic      ge      [MAX_K];
  cell_ctl_t ctl     [MAX_K];

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign kind          = kind_e'(s_axis_tuser);

  assign new_entry.left_id  = s_axis_tdata[31:0];
  assign new_entry.right_id = s_axis_tdata[63:32];
  assign new_entry.score    = s_axis_tdata[95:64];

  // Clamp top_k to 1..MAX_K.
  always_comb begin
    if (top_k_q == '0) begin
      k_eff = KW'(1);
    end else if (32'(top_k_q) > MAX_K) begin
      k_eff = KW'(MAX_K);
    end else begin
      k_eff = KW'(top_k_q);
    end
  end

  assign n_ins = (fill_q > k_eff) ? k_eff : fill_q;
  assign lim   = (n_ins == k_eff) ? k_eff : n_ins + KW'(1);
  assign kidx  = IDXW'(k_eff - KW'(1));

  assign do_ins = in_acc && (kind == KIND_INSERT);
  assign do_rot = (state_q == ST_DRAIN) && out_free;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    assign ctl[i].ins   = do_ins;
    assign ctl[i].rot   = do_rot;
    assign ctl[i].occ   = KW'(i) < n_ins;
    assign ctl[i].inlim = KW'(i) < lim;
    assign ctl[i].tail  = fill_q == KW'(i + 1);

    tkspl_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[i]),
      .new_i     (new_entry),
      .prev_ge_i ((i == 0) ? 1'b0 : ge[(i == 0) ? 0 : i - 1]),
      .prev_i    ((i == 0) ? entry_t'('0) : cell_q[(i == 0) ? 0 : i - 1]),
      .next_i    ((i == MAX_K - 1) ? entry_t'('0) : cell_q[(i == MAX_K - 1) ? i : i + 1]),
      .head_i    (cell_q[0]),
      .ge_o      (ge[i]),
      .entry_o   (cell_q[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    full_d      = full_q;
    prune_d     = prune_q;
    sq_d        = sq_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_ev_d    = out_ev_q;
    out_last_d  = out_last_q;
    out_entry_d = out_entry_q;
    out_thr_d   = out_thr_q;
    out_sq_d    = out_sq_q;
    out_held_d  = out_held_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (kind)
            KIND_INSERT: begin
              full_d  = (n_ins == k_eff);
              fill_d  = (n_ins == k_eff) ? k_eff : n_ins + KW'(1);
              state_d = ST_PRUNE;
            end
            KIND_DRAIN: begin
              cnt_d   = '0;
              state_d = (fill_q == '0) ? ST_STAT : ST_DRAIN;
            end
            KIND_CLEAR: begin
              fill_d  = '0;
              prune_d = ThreshReset;
              state_d = ST_SQ;
            end
            default: begin
              state_d = ST_STAT;
            end
          endcase
        end
      end
      ST_PRUNE: begin
        if (full_q) begin
          prune_d = cell_q[kidx].score;
        end
        state_d = ST_SQ;
      end
      ST_SQ: begin
        sq_d    = 64'(prune_q) * 64'(prune_q);
        state_d = ST_STAT;
      end
      ST_STAT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = 1'b0;
          out_last_d  = 1'b1;
          out_entry_d = '0;
          out_thr_d   = prune_q;
          out_sq_d    = sq_q;
          out_held_d  = HeldW'(fill_q);
          state_d     = ST_IDLE;
        end
      end
      ST_DRAIN: begin
        // Emit the head word and rotate the row by one place.
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ev_d    = 1'b1;
          out_last_d  = (cnt_q == fill_q - KW'(1));
          out_entry_d = cell_q[0];
          out_thr_d   = prune_q;
          out_sq_d    = sq_q;
          out_held_d  = HeldW'(fill_q);
          cnt_d       = cnt_q + KW'(1);
          if (cnt_q == fill_q - KW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      top_k_q     <= TopKReset;
      fill_q      <= '0;
      cnt_q       <= '0;
      full_q      <= 1'b0;
      prune_q     <= ThreshReset;
      sq_q        <= ThreshSqReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_valid_i) begin
        top_k_q <= cfg_data_i;
      end
      fill_q      <= fill_d;
      cnt_q       <= cnt_d;
      full_q      <= full_d;
      prune_q     <= prune_d;
      sq_q        <= sq_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ev_q    <= out_ev_d;
    out_last_q  <= out_last_d;
    out_entry_q <= out_entry_d;
    out_thr_q   <= out_thr_d;
    out_sq_q    <= out_sq_d;
    out_held_q  <= out_held_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_held_q, out_sq_q, out_thr_q, out_entry_q.score,
                          out_entry_q.right_id, out_entry_q.left_id};

endmodule

@@ rtl/core/tkspl_cell.sv @@
// One position of the sorted list: holds a pair and shifts or rotates it.
module tkspl_cell
  import tkspl_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  entry_t    new_i,
  input  logic      prev_ge_i,
  input  entry_t    prev_i,
  input  entry_t    next_i,
  input  entry_t    head_i,
  output logic      ge_o,
  output entry_t    entry_o
);

  entry_t entry_q;
  entry_t entry_d;

  // An empty position counts as greater or equal, so the new pair lands at the end.
  assign ge_o    = !ctl_i.occ || (entry_q.score >= new_i.score);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins && ctl_i.inlim) begin
      if (prev_ge_i) begin
        entry_d = prev_i;
      end else if (ge_o) begin
        entry_d = new_i;
      end
    end else if (ctl_i.rot) begin
      entry_d = ctl_i.tail ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ rtl/core/tkspl_checker.sv @@
// Port-level checks for the top-k smallest pair list, bound to the top level.
module tkspl_checker
  import tkspl_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [CfgW-1:0]     cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic [KindW-1:0]    s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  // Hold a stalled word.
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // Status words end their item and carry no entry.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata[95:0] == '0))
    else $error("status word malformed");

  // The square always matches the threshold it travels with.
  a_square: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tdata[191:128] == 64'(m_axis_tdata[127:96]) * 64'(m_axis_tdata[127:96]))
    else $error("threshold square mismatch");

  // Hold off new items until a drain has emitted its last word.
  a_no_accept_mid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser && !m_axis_tlast |-> !s_axis_tready)
    else $error("input accepted during a drain");

endmodule

bind top_k_smallest_pair_list_top tkspl_checker u_tkspl_checker (.*);

@@ verif/tb_top.sv @@
// Testbench for the top-k smallest pair list: stream driver, monitor and list predictor.
`timescale 1ns / 100ps

module tb_top;
  import tkspl_pkg::*;

  localparam int unsigned MAX_K         = 32;
  localparam int unsigned LIMIT         = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned NUM_PHASES    = 10;

  typedef struct {
    kind_e             kind;
    logic [IdW-1:0]    left_id;
    logic [IdW-1:0]    right_id;
    logic [ScoreW-1:0] score;
    bit                settle;   // hold this word until every result is back
  } pair_item_t;

  typedef struct {
    logic                entry_valid;
    logic [IdW-1:0]      left_id;
    logic [IdW-1:0]      right_id;
    logic [ScoreW-1:0]   score;
    logic [ScoreW-1:0]   threshold;
    logic [2*ScoreW-1:0] threshold_sq;
    logic [HeldW-1:0]    held;
    logic                last;
  } list_word_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgW-1:0]     cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [KindW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  top_k_smallest_pair_list_top #(
    .MAX_K(MAX_K)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Predicted list state
  logic [ScoreW-1:0] list_score [MAX_K];
  logic [IdW-1:0]    list_left  [MAX_K];
  logic [IdW-1:0]    list_right [MAX_K];
  int unsigned       list_fill  = 0;
  logic [ScoreW-1:0] list_thr   = ThreshReset;
  logic [CfgW-1:0]   list_top_k = TopKReset;

  pair_item_t  pair_feed_q [$];
  list_word_t  list_words_q [$];
  pair_item_t  tx_item;
  int unsigned tx_gap    = 0;
  int unsigned rx_stall  = 0;
  bit          idle_tx   = 1'b1;
  bit          idle_rx   = 1'b1;
  int unsigned n_errors  = 0;
  int unsigned n_words   = 0;
  int unsigned n_entries = 0;
  int unsigned n_cfg     = 0;
  int unsigned n_kind [4] = '{0, 0, 0, 0};
  logic [CfgW-1:0] phase_k [NUM_PHASES];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (LIMIT) @(posedge clk_i);
    $error("timeout after %0d cycles, %0d words still expected", LIMIT, list_words_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void push_word(logic valid, logic [IdW-1:0] l, logic [IdW-1:0] r,
                                    logic [ScoreW-1:0] s, logic last);
    list_word_t w;
    w.entry_valid  = valid;
    w.left_id      = l;
    w.right_id     = r;
    w.score        = s;
    w.threshold    = list_thr;
    w.threshold_sq = {32'd0, list_thr} * {32'd0, list_thr};
    w.held         = list_fill[HeldW-1:0];
    w.last         = last;
    list_words_q   = {list_words_q, w};
  endfunction

  function automatic void insert_pair(logic [IdW-1:0] l, logic [IdW-1:0] r,
                                      logic [ScoreW-1:0] s);
    int unsigned k, n, pos;
    k = (list_top_k == 0) ? 1 : (list_top_k > MAX_K) ? MAX_K : int'(list_top_k);
    n = (list_fill > k) ? k : list_fill;
    pos = n;
    // new pair goes ahead of the first entry that is no better
    for (int unsigned i = 0; i < n; i++)
      if (pos == n && list_score[i] >= s) pos = i;
    if (n == k) begin
      if (pos < k) begin
        for (int unsigned i = k - 1; i > pos; i--) begin
          list_score[i] = list_score[i-1];
          list_left[i]  = list_left[i-1];
          list_right[i] = list_right[i-1];
        end
        list_score[pos] = s;
        list_left[pos]  = l;
        list_right[pos] = r;
      end
      list_fill = k;
      list_thr  = list_score[k-1];
    end else begin
      for (int unsigned i = n; i > pos; i--) begin
        list_score[i] = list_score[i-1];
        list_left[i]  = list_left[i-1];
        list_right[i] = list_right[i-1];
      end
      list_score[pos] = s;
      list_left[pos]  = l;
      list_right[pos] = r;
      list_fill = n + 1;
    end
  endfunction

  function automatic void predict_list_words(kind_e kind, logic [IdW-1:0] l,
                                             logic [IdW-1:0] r, logic [ScoreW-1:0] s);
    case (kind)
      KIND_INSERT: begin
        insert_pair(l, r, s);
        push_word(1'b0, '0, '0, '0, 1'b1);
      end
      KIND_DRAIN: begin
        if (list_fill == 0) begin
          push_word(1'b0, '0, '0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < list_fill; i++)
            push_word(1'b1, list_left[i], list_right[i], list_score[i], i + 1 == list_fill);
        end
      end
      KIND_CLEAR: begin
        list_fill = 0;
        list_thr  = ThreshReset;
        push_word(1'b0, '0, '0, '0, 1'b1);
      end
      default: begin
        push_word(1'b0, '0, '0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic int unsigned pick_gap(bit en);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!en || roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Narrow values give ties and evictions, wide ones toggle every bit
  function automatic logic [ScoreW-1:0] pick_score();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    if (roll == 2) return ThreshReset;
    if (roll < 6) return $urandom_range(0, 24);
    return $urandom;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      n_errors++;
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
    end
  endfunction

  // Driver: predict on acceptance, then present the next pending word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_list_words(kind_e'(s_axis_tuser), s_axis_tdata[31:0], s_axis_tdata[63:32],
                           s_axis_tdata[95:64]);
        n_kind[s_axis_tuser]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap != 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pair_feed_q.size() != 0 &&
                     !(pair_feed_q[0].settle && list_words_q.size() != 0)) begin
          tx_item = pair_feed_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {tx_item.score, tx_item.right_id, tx_item.left_id};
          s_axis_tuser  <= tx_item.kind;
          tx_gap = pick_gap(idle_tx);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    list_word_t w;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words++;
        if (m_axis_tuser) n_entries++;
        if (list_words_q.size() == 0) begin
          n_errors++;
          $error("output word with nothing expected: tdata 0x%0h", m_axis_tdata);
        end else begin
          w = list_words_q.pop_front();
          check_field("entry_valid", w.entry_valid, m_axis_tuser);
          check_field("out_left_id", w.left_id, m_axis_tdata[31:0]);
          check_field("out_right_id", w.right_id, m_axis_tdata[63:32]);
          check_field("out_score", w.score, m_axis_tdata[95:64]);
          check_field("threshold", w.threshold, m_axis_tdata[127:96]);
          check_field("threshold_sq", w.threshold_sq, m_axis_tdata[191:128]);
          check_field("held", w.held, m_axis_tdata[197:192]);
          check_field("tdata padding", '0, m_axis_tdata[OutDataW-1:198]);
          check_field("last", w.last, m_axis_tlast);
        end
      end
      if (rx_stall == 0 && idle_rx && $urandom_range(0, 99) < 30) rx_stall = pick_gap(1'b1);
      if (rx_stall != 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_item(kind_e kind, logic [IdW-1:0] l, logic [IdW-1:0] r,
                          logic [ScoreW-1:0] s, bit settle);
    pair_item_t it;
    it.kind     = kind;
    it.left_id  = l;
    it.right_id = r;
    it.score    = s;
    it.settle   = settle;
    pair_feed_q = {pair_feed_q, it};
  endtask

  // Wait for an idle block: nothing pending, nothing in flight, nothing expected
  task automatic settle_down();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(posedge clk_i);
      if (pair_feed_q.size() == 0 && !s_axis_tvalid && list_words_q.size() == 0) quiet++;
      else quiet = 0;
    end
  endtask

  task automatic write_top_k(logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    list_top_k = value;
    n_cfg++;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    kind_e       kind;
    int unsigned roll;
    int unsigned n_rand;
    phase_k = '{6'd32, 6'd3, 6'd0, 6'd63, 6'd1, 6'd10, 6'd17, 6'd33, 6'd5, 6'd2};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset value of top_k
    add_item(KIND_DRAIN, '0, '0, '0, 1'b0);
    add_item(KIND_NOP, '1, '1, '1, 1'b0);
    add_item(KIND_CLEAR, '0, '0, '0, 1'b0);
    add_item(KIND_INSERT, '0, '0, '0, 1'b0);
    add_item(KIND_INSERT, '1, '1, '1, 1'b0);
    add_item(KIND_INSERT, 32'd1, 32'd2, 32'd5, 1'b0);
    add_item(KIND_INSERT, 32'd3, 32'd4, 32'd5, 1'b0);
    add_item(KIND_INSERT, 32'd5, 32'd6, 32'd0, 1'b0);
    add_item(KIND_DRAIN, '0, '0, '0, 1'b0);
    // overfill so the worst entries get evicted
    for (int i = 0; i < 7; i++)
      add_item(KIND_INSERT, 32'h100 + i, 32'h200 + i, 32'd100 + i, 1'b0);
    add_item(KIND_INSERT, 32'hDEAD_0001, 32'hBEEF_0001, '1, 1'b0);
    add_item(KIND_INSERT, 32'hDEAD_0002, 32'hBEEF_0002, ThreshReset, 1'b0);
    add_item(KIND_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'd1, 1'b1);
    add_item(KIND_DRAIN, '0, '0, '0, 1'b0);
    add_item(KIND_CLEAR, '0, '0, '0, 1'b0);
    add_item(KIND_DRAIN, '0, '0, '0, 1'b0);
    settle_down();

    // Random phases, one top_k setting each; the second lowers top_k below the fill
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_top_k(phase_k[p]);
      idle_tx = (p % 3 != 1);
      idle_rx = (p % 4 != 2);
      if (p != 0) add_item(KIND_DRAIN, $urandom, $urandom, $urandom, 1'b0);
      n_rand = (p == 0) ? 36 : 4;
      for (int i = 0; i < n_rand; i++) begin
        roll = $urandom_range(0, 99);
        if (p == 0 || roll < 68) kind = KIND_INSERT;
        else if (roll < 84) kind = KIND_DRAIN;
        else if (roll < 92) kind = KIND_CLEAR;
        else kind = KIND_NOP;
        add_item(kind, $urandom, $urandom, pick_score(),
                 (p == 4 && i == 0) || $urandom_range(0, 99) < 5);
      end
      if (p == 0) add_item(KIND_DRAIN, $urandom, $urandom, $urandom, 1'b0);
      settle_down();
    end

    $display("Run covered %0d inserts, %0d drains, %0d clears and %0d unused kinds",
             n_kind[KIND_INSERT], n_kind[KIND_DRAIN], n_kind[KIND_CLEAR], n_kind[KIND_NOP]);
    $display("over %0d top_k writes; %0d output words, %0d drained entries, %0d mismatches.",
             n_cfg, n_words, n_entries, n_errors);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ top_k_smallest_pair_list_top.f @@
rtl/core/tkspl_pkg.sv
rtl/core/tkspl_cell.sv
rtl/core/top_k_smallest_pair_list_top.sv
rtl/core/tkspl_checker.sv
verif/tb_top.sv
